// ===== design/bfs_pkg.sv =====
package bfs_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;
  localparam int PixW        = 8;
  localparam int DimW        = 11;
  localparam int PosW        = 10;
  localparam int SumW        = 12;
  localparam int RecipW      = 13;
  localparam int RecipShift  = 16;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrW    = 2;
  localparam int FifoCntW    = 3;
  localparam int AddrW       = 3;
  localparam int DataW       = 32;

  // floor(x/9) == (x*7282) >> 16 for every 3x3 sum of 8-bit pixels
  localparam logic [RecipW-1:0] Recip9 = 13'd7282;

  localparam logic [DimW-1:0] DimMin   = 11'd3;
  localparam logic [DimW-1:0] WidthMax = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax = DimW'(MaxHeight);

  // register index, taken from paddr[2]
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            restart;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] upper;
    logic [PixW-1:0] middle;
    logic [PixW-1:0] pixel;
    logic            emit;
    logic            interior;
    logic [PosW-1:0] orow;
    logic [PosW-1:0] ocol;
  } item_t;

endpackage

// ===== design/box_filter_3x3_stream_top.sv =====
// 3x3 box filter (truncated mean) over a raster-order stream of 8-bit pixels.
// Input: pixel_i with pixel_valid_i / pixel_ready_o, one request per pixel,
// row by row over a frame of width x height set through the APB port
// (register 0 at 0x0: width, register 1 at 0x4: height, both 11 bits,
// clamped to 3..1024). Any register write restarts the frame at row 0.
// Output: value_o, out_row_o, out_col_o with out_valid_o / out_ready_i.
// Border positions give zero. The first width+1 pixels of a frame give no
// result; the last width+1 border results of a frame are not sent.
// Pixel (r, c) gives the result for (r-1, c-1) via the front stage, queue,
// window, sum and output registers. Throughput: one pixel per cycle when the
// queue has room, set by one read and one write per row store each cycle.
// A 4-entry queue separates the input/line-store front from the window and
// divide back; when the receiver stalls the back holds, the queue fills and
// pixel_ready_o drops after at most 4 further pixels.
// Reset: position returns to row 0 column 0, the queue and pipeline empty,
// and both dimension registers read 1024. Line store contents are not reset.
module box_filter_3x3_stream_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bfs_pkg::AddrW-1:0] paddr,
  input  logic [bfs_pkg::DataW-1:0] pwdata,
  output logic [bfs_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      pixel_valid_i,
  output logic                      pixel_ready_o,
  input  logic [bfs_pkg::PixW-1:0]  pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bfs_pkg::PixW-1:0]  value_o,
  output logic [bfs_pkg::PosW-1:0]  out_row_o,
  output logic [bfs_pkg::PosW-1:0]  out_col_o
);
  import bfs_pkg::*;

  logic [DimW-1:0]     width_q, height_q;
  logic                cfg_wr;
  cfg_t                cfg;
  logic                push, pop, fifo_valid;
  item_t               push_item, pop_item;
  logic [FifoCntW-1:0] fifo_cnt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegHeight) ? DataW'(height_q) : DataW'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthMax;
      height_q <= HeightMax;
    end else if (cfg_wr) begin
      if (paddr[2] == RegWidth) begin
        width_q <= pwdata[DimW-1:0];
      end else begin
        height_q <= pwdata[DimW-1:0];
      end
    end
  end

  always_comb begin
    cfg.width   = (width_q < DimMin) ? DimMin :
                  (width_q > WidthMax) ? WidthMax : width_q;
    cfg.height  = (height_q < DimMin) ? DimMin :
                  (height_q > HeightMax) ? HeightMax : height_q;
    cfg.restart = cfg_wr;
  end

  bfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .fifo_cnt_i    (fifo_cnt),
    .push_o        (push),
    .item_o        (push_item)
  );

  bfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .item_o  (pop_item),
    .cnt_o   (fifo_cnt)
  );

  bfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o)
  );

endmodule

// ===== design/bfs_front.sv =====
module bfs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfs_pkg::cfg_t                cfg_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [bfs_pkg::PixW-1:0]     pixel_i,
  input  logic [bfs_pkg::FifoCntW-1:0] fifo_cnt_i,
  output logic                         push_o,
  output bfs_pkg::item_t               item_o
);
  import bfs_pkg::*;

  logic [PixW-1:0] upper_mem  [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];

  logic [PosW-1:0] row_q, row_d, col_q, col_d;
  logic            s1_v_q;
  logic [PixW-1:0] upper_rd_q, middle_rd_q, px_q;
  logic            emit_q, emit_d, interior_q, interior_d;
  logic [PosW-1:0] orow_q, orow_d, ocol_q, ocol_d, wr_addr_q;
  logic [DimW-1:0] col_inc, row_inc, width_m1;
  logic [FifoCntW:0] occupancy;
  logic            accept;

  assign occupancy     = {1'b0, fifo_cnt_i} + {{FifoCntW{1'b0}}, s1_v_q};
  assign pixel_ready_o = occupancy < (FifoCntW + 1)'(FifoDepth);
  assign accept        = pixel_valid_i && pixel_ready_o;

  assign width_m1 = cfg_i.width - DimW'(1);
  assign col_inc  = {1'b0, col_q} + DimW'(1);
  assign row_inc  = {1'b0, row_q} + DimW'(1);

  always_comb begin
    emit_d = (row_q >= PosW'(2)) || ((row_q == PosW'(1)) && (col_q != '0));
    if (col_q != '0) begin
      orow_d = row_q - PosW'(1);
      ocol_d = col_q - PosW'(1);
    end else begin
      orow_d = row_q - PosW'(2);
      ocol_d = width_m1[PosW-1:0];
    end
    interior_d = (orow_d != '0) && (ocol_d != '0) &&
                 (({1'b0, orow_d} + DimW'(2)) <= cfg_i.height) &&
                 (({1'b0, ocol_d} + DimW'(2)) <= cfg_i.width);
    if (col_inc >= cfg_i.width) begin
      col_d = '0;
      row_d = (row_inc >= cfg_i.height) ? '0 : row_inc[PosW-1:0];
    end else begin
      col_d = col_inc[PosW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      if (cfg_i.restart) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q       <= pixel_i;
      emit_q     <= emit_d;
      interior_q <= interior_d;
      orow_q     <= orow_d;
      ocol_q     <= ocol_d;
      wr_addr_q  <= col_q;
    end
  end

  // middle row store: read old value, write new pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      middle_rd_q         <= middle_mem[col_q];
      middle_mem[col_q]   <= pixel_i;
    end
  end

  // upper row store: takes the displaced middle entry in the cycle after it is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_rd_q <= upper_mem[col_q];
    end
    if (s1_v_q) begin
      upper_mem[wr_addr_q] <= middle_rd_q;
    end
  end

  assign push_o          = s1_v_q;
  assign item_o.upper    = upper_rd_q;
  assign item_o.middle   = middle_rd_q;
  assign item_o.pixel    = px_q;
  assign item_o.emit     = emit_q;
  assign item_o.interior = interior_q;
  assign item_o.orow     = orow_q;
  assign item_o.ocol     = ocol_q;

endmodule

// ===== design/bfs_fifo.sv =====
module bfs_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bfs_pkg::item_t               item_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output bfs_pkg::item_t               item_o,
  output logic [bfs_pkg::FifoCntW-1:0] cnt_o
);
  import bfs_pkg::*;

  item_t               slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/bfs_back.sv =====
module bfs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fifo_valid_i,
  input  bfs_pkg::item_t           item_i,
  output logic                     pop_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [bfs_pkg::PixW-1:0] value_o,
  output logic [bfs_pkg::PosW-1:0] out_row_o,
  output logic [bfs_pkg::PosW-1:0] out_col_o
);
  import bfs_pkg::*;

  typedef struct packed {
    logic            emit;
    logic            interior;
    logic [PosW-1:0] orow;
    logic [PosW-1:0] ocol;
  } meta_t;

  localparam int ProdW = SumW + RecipW;

  logic [PixW-1:0] win_q [3][3];
  logic            b1_v_q, b2_v_q, out_v_q;
  meta_t           b1_q, b2_q;
  logic [SumW-1:0] sum_d, sum_q;
  logic [ProdW-1:0] prod;
  logic [PixW-1:0] value_q;
  logic [PosW-1:0] row_q, col_q;
  logic            en;

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && fifo_valid_i;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum_d = sum_d + SumW'(win_q[i][j]);
      end
    end
  end

  assign prod = ProdW'(sum_q) * ProdW'(Recip9);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (en) begin
      b1_v_q  <= fifo_valid_i;
      b2_v_q  <= b1_v_q;
      out_v_q <= b2_v_q && b2_q.emit;
      if (fifo_valid_i) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= item_i.upper;
        win_q[1][2] <= item_i.middle;
        win_q[2][2] <= item_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q.emit     <= item_i.emit;
      b1_q.interior <= item_i.interior;
      b1_q.orow     <= item_i.orow;
      b1_q.ocol     <= item_i.ocol;
      b2_q          <= b1_q;
      sum_q         <= sum_d;
      value_q       <= b2_q.interior ? prod[RecipShift+PixW-1:RecipShift] : '0;
      row_q         <= b2_q.orow;
      col_q         <= b2_q.ocol;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;

endmodule

// ===== design/bfs_checker.sv =====
module bfs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [bfs_pkg::PixW-1:0]  value_o,
  input logic [bfs_pkg::PosW-1:0]  out_row_o,
  input logic [bfs_pkg::PosW-1:0]  out_col_o
);

  // border row 0 and column 0 always filter to zero
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_row_o == '0 || out_col_o == '0) |-> value_o == '0)
    else $error("nonzero value on frame border");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(value_o) && $stable(out_row_o) && $stable(out_col_o))
    else $error("result changed while stalled");

  // a result needs an accepted pixel to pass the front, queue and back registers first
  a_no_early_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result right after reset");

endmodule

bind box_filter_3x3_stream_top bfs_checker u_bfs_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bfs_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } mean_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrW-1:0]     paddr         = '0;
  logic [DataW-1:0]     pwdata        = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 pixel_valid_i = 1'b0;
  logic                 pixel_ready_o;
  logic [PixW-1:0]      pixel_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [PixW-1:0]      value_o;
  logic [PosW-1:0]      out_row_o;
  logic [PosW-1:0]      out_col_o;

  // filter state mirror
  logic [DimW-1:0]      frame_width  = DimW'(MaxWidth);
  logic [DimW-1:0]      frame_height = DimW'(MaxHeight);
  logic [PixW-1:0]      line_above [MaxWidth];
  logic [PixW-1:0]      line_prev  [MaxWidth];
  logic [PixW-1:0]      win [3][3];
  int                   row_pos = 0;
  int                   col_pos = 0;
  mean_result_t         pending_means [$];

  int pixels_taken  = 0;
  int results_taken = 0;
  int apb_done      = 0;
  int cfg_writes    = 0;
  int mismatches    = 0;
  bit send_idle     = 1'b0;
  bit recv_idle     = 1'b0;
  int ready_seen    = 0;
  int ready_hold    = 0;

  box_filter_3x3_stream_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    foreach (line_above[k]) begin
      line_above[k] = '0;
      line_prev[k]  = '0;
    end
    foreach (win[a, b]) win[a][b] = '0;
  end

  function automatic int clamp_dim(input logic [DimW-1:0] raw, input int hi);
    if (raw < DimMin) return int'(DimMin);
    if (int'(raw) > hi) return hi;
    return int'(raw);
  endfunction

  function automatic void box_mean_predict(input logic [PixW-1:0] px);
    int w, h, r, c, orow, ocol, total, i, j;
    mean_result_t res;
    w = clamp_dim(frame_width, MaxWidth);
    h = clamp_dim(frame_height, MaxHeight);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]     = line_above[c];
    win[1][2]     = line_prev[c];
    win[2][2]     = px;
    line_above[c] = line_prev[c];
    line_prev[c]  = px;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        orow = r - 1;
        ocol = c - 1;
      end else begin
        orow = r - 2;
        ocol = w - 1;
      end
      res.value = '0;
      if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
        total = 0;
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++)
            total += win[i][j];
        res.value = PixW'(total / 9);
      end
      res.row = PosW'(orow);
      res.col = PosW'(ocol);
      pending_means.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // sample requests and results at the rising edge
  always @(posedge clk_i) begin
    mean_result_t want;
    if (rst_ni) begin
      if (psel && penable && pready) begin
        apb_done++;
        if (pwrite) begin
          if (paddr[2] == RegWidth) frame_width = pwdata[DimW-1:0];
          else frame_height = pwdata[DimW-1:0];
          row_pos = 0;
          col_pos = 0;
          cfg_writes++;
        end else if (paddr[2] == RegWidth) begin
          if (prdata !== 32'(frame_width)) report_mismatch("width read", prdata, frame_width);
        end else begin
          if (prdata !== 32'(frame_height))
            report_mismatch("height read", prdata, frame_height);
        end
      end
      if (pixel_valid_i && pixel_ready_o) begin
        box_mean_predict(pixel_i);
        pixels_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        results_taken++;
        if (pending_means.size() == 0) begin
          report_mismatch("unexpected result at column", out_col_o, 0);
        end else begin
          want = pending_means.pop_front();
          if (value_o !== want.value) report_mismatch("filtered value", value_o, want.value);
          if (out_row_o !== want.row) report_mismatch("output row", out_row_o, want.row);
          if (out_col_o !== want.col) report_mismatch("output column", out_col_o, want.col);
        end
      end
    end
  end

  // receiver: random stall after each result while recv_idle is set
  always @(negedge clk_i) begin
    if (results_taken != ready_seen) begin
      ready_seen = results_taken;
      ready_hold = recv_idle ? $urandom_range(0, 13) : 0;
    end
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] px);
    int gap, target;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= px;
    target = pixels_taken + 1;
    do @(negedge clk_i); while (pixels_taken < target);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [DataW-1:0] data);
    int target;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    target = apb_done + 1;
    do @(negedge clk_i); while (apb_done < target);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained;
    pixel_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    // frame-start pixels give no result but may still be in flight
    repeat (16) @(negedge clk_i);
  endtask

  function automatic logic [PixW-1:0] random_pixel;
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PixW'($urandom_range(0, 255));
  endfunction

  task automatic test_register_defaults;
    apb_access(1'b0, RegWidth, '0);
    apb_access(1'b0, RegHeight, '0);
    repeat (12) send_pixel(random_pixel());
    wait_drained;
  endtask

  task automatic test_register_readback;
    apb_access(1'b1, RegWidth, 32'hFFFF_FFFF);
    apb_access(1'b0, RegWidth, '0);
    apb_access(1'b1, RegHeight, 32'hAAAA_A800);
    apb_access(1'b0, RegHeight, '0);
    apb_access(1'b1, RegHeight, 32'h0000_0555);
    apb_access(1'b0, RegHeight, '0);
  endtask

  // width 2 and height 0 clamp to a 3x3 frame
  task automatic test_extreme_pixels;
    int k;
    apb_access(1'b1, RegWidth, 32'd2);
    apb_access(1'b1, RegHeight, 32'd0);
    repeat (9) send_pixel(8'hFF);
    for (k = 0; k < 9; k++) send_pixel((k % 2) ? 8'h00 : 8'hFF);
    send_pixel(8'h00);
    wait_drained;
  endtask

  task automatic test_restart_mid_frame;
    int k;
    apb_access(1'b1, RegWidth, 32'd4);
    apb_access(1'b1, RegHeight, 32'd1);
    for (k = 0; k < 7; k++) send_pixel(8'(8'hF0 + k));
    wait_drained;
    apb_access(1'b1, RegHeight, 32'd3);
    for (k = 0; k < 13; k++) send_pixel(8'(k * 19));
    wait_drained;
  endtask

  task automatic test_max_width;
    recv_idle = 1'b1;
    apb_access(1'b1, RegWidth, 32'h7FF);
    apb_access(1'b1, RegHeight, 32'd3);
    repeat (40) send_pixel(random_pixel());
    wait_drained;
  endtask

  task automatic test_max_height;
    recv_idle = 1'b0;
    apb_access(1'b1, RegWidth, 32'd3);
    apb_access(1'b1, RegHeight, 32'd1025);
    repeat (3 * 10 + 5) send_pixel(random_pixel());
    wait_drained;
  endtask

  task automatic test_random_frames;
    int budget, n, w, h, pick;
    logic [DimW-1:0] w_raw, h_raw;
    budget = 0;
    while (budget < 540) begin
      pick  = $urandom_range(0, 9);
      w_raw = (pick == 0) ? DimW'($urandom_range(0, 2)) : DimW'($urandom_range(3, 16));
      h_raw = (pick == 1) ? DimW'($urandom_range(0, 2)) : DimW'($urandom_range(3, 10));
      if ($urandom_range(0, 3) != 0)
        apb_access(1'b1, RegWidth, ($urandom() & ~32'h7FF) | 32'(w_raw));
      if ($urandom_range(0, 3) != 0)
        apb_access(1'b1, RegHeight, ($urandom() & ~32'h7FF) | 32'(h_raw));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      w = clamp_dim(frame_width, MaxWidth);
      h = clamp_dim(frame_height, MaxHeight);
      n = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
      repeat (n) send_pixel(random_pixel());
      budget += n;
      wait_drained;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_defaults;
    test_register_readback;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_extreme_pixels;
    test_restart_mid_frame;
    send_idle = 1'b0;
    test_max_width;
    test_max_height;
    test_random_frames;
    wait_drained;
    $display("Ran %0d pixels through the filter over %0d register writes,", pixels_taken,
             cfg_writes);
    $display("checked %0d results, %0d mismatches.", results_taken, mismatches);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
